// File: rtl/lftp_pkg.sv
// Shared constants and types of the lottery/FIFO task picker.
package lftp_pkg;

  localparam int SLOT_COUNT_DEF  = 64;
  localparam int TICKET_BITS_DEF = 16;

  localparam int REQ_W        = 2;
  localparam int SLOT_IDX_W   = 6;
  localparam int ORDER_W      = 31;
  localparam int TICKETS_IN_W = 16;
  localparam int DRAW_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [DRAW_W-1:0] LCG_MUL_RESET = 32'd1664525;
  localparam logic [DRAW_W-1:0] LCG_INC_RESET = 32'd1013904223;

  localparam logic [CFG_IDX_W-1:0] CFG_PICK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LCG_MUL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LCG_INC   = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_SET_RUN = 2'd1,
    REQ_PICK    = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SUM,
    ST_DIV,
    ST_SCAN,
    ST_FIFO,
    ST_DONE
  } state_e;

endpackage

// File: rtl/lftp_slot_mem.sv
// Slot table memory: arrival order and ticket count per slot, registered read.
module lftp_slot_mem #(
  parameter int SLOT_COUNT  = lftp_pkg::SLOT_COUNT_DEF,
  parameter int TICKET_BITS = lftp_pkg::TICKET_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]       waddr_i,
  input  logic [lftp_pkg::ORDER_W-1:0]        worder_i,
  input  logic [TICKET_BITS-1:0]              wtickets_i,
  input  logic                                re_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]       raddr_i,
  output logic [lftp_pkg::ORDER_W-1:0]        rorder_o,
  output logic [TICKET_BITS-1:0]              rtickets_o
);
  import lftp_pkg::*;

  localparam int ENTRY_W = ORDER_W + TICKET_BITS;

  logic [ENTRY_W-1:0] mem_q [SLOT_COUNT];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {worder_i, wtickets_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rorder_o   = rdata_q[ENTRY_W-1:TICKET_BITS];
  assign rtickets_o = rdata_q[TICKET_BITS-1:0];

endmodule

// File: rtl/lftp_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
module lftp_mod_unit #(
  parameter int DIV_W = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lftp_pkg::DRAW_W-1:0]   dividend_i,
  input  logic [DIV_W-1:0]              divisor_i,
  output logic                          done_o,
  output logic [DIV_W-1:0]              rem_o
);
  import lftp_pkg::*;

  localparam int DCNT_W = $clog2(DRAW_W + 1);

  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DRAW_W-1:0] dvd_q;
  logic [DIV_W-1:0]  dvs_q;
  logic [DIV_W-1:0]  rem_q;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem_q, dvd_q[DRAW_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DCNT_W'(DRAW_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - DCNT_W'(1);
        done_q <= (cnt_q == DCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DRAW_W-2:0], 1'b0};
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/lottery_fifo_task_picker_unit.sv
// Top level of the lottery/FIFO task picker: sequencer, slot flags, config, results.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | req_type_i slot_index_i runnable_in_i          | start && !busy
//            | order_in_i tickets_in_i tick_now_i             |
//  result    | granted_o granted_slot_o first_run_o           | done_o, one cycle, no stall
//  config    | cfg_idx_i cfg_wdata_i                          | cfg_we_i
//
//  Load, set-runnable and unused requests leave busy low; done_o follows in the next cycle.
//  FIFO pick: busy during one table sweep through the slot memory port.
//  Lottery pick: busy through a ticket sum sweep, 32-step remainder,
//  then a scan sweep; the single memory read port sets the sweep length.
//  A zero ticket total ends the lottery pick after the sum sweep.
//  Reset clears all runnable and has-run flags at once; no clearing pass.
//  The receiver cannot stall: done_o pulses for one cycle per item.
module lottery_fifo_task_picker_unit #(
  parameter int SLOT_COUNT  = lftp_pkg::SLOT_COUNT_DEF,
  parameter int TICKET_BITS = lftp_pkg::TICKET_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [lftp_pkg::REQ_W-1:0]          req_type_i,
  input  logic [lftp_pkg::SLOT_IDX_W-1:0]     slot_index_i,
  input  logic                                runnable_in_i,
  input  logic [lftp_pkg::ORDER_W-1:0]        order_in_i,
  input  logic [lftp_pkg::TICKETS_IN_W-1:0]   tickets_in_i,
  input  logic [lftp_pkg::DRAW_W-1:0]         tick_now_i,
  output logic                                done_o,
  output logic                                granted_o,
  output logic [lftp_pkg::SLOT_IDX_W-1:0]     granted_slot_o,
  output logic                                first_run_o,
  input  logic                                cfg_we_i,
  input  logic [lftp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lftp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import lftp_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam int TOT_W = TICKET_BITS + IDX_W;

  // configuration
  logic              pick_mode_q;
  logic [DRAW_W-1:0] lcg_mul_q;
  logic [DRAW_W-1:0] lcg_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_mode_q <= 1'b0;
      lcg_mul_q   <= LCG_MUL_RESET;
      lcg_inc_q   <= LCG_INC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PICK_MODE: pick_mode_q <= cfg_wdata_i[0];
        CFG_LCG_MUL:   lcg_mul_q   <= cfg_wdata_i;
        CFG_LCG_INC:   lcg_inc_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request decode
  state_e state_q, state_d;
  logic   accept;
  logic   idx_ok;
  logic [IDX_W-1:0] widx;
  logic [IDX_W+SLOT_IDX_W-1:0] sidx_ext;
  logic [TICKET_BITS+TICKETS_IN_W-1:0] tk_ext;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign idx_ok   = 32'(slot_index_i) < 32'(SLOT_COUNT);
  assign sidx_ext = {{IDX_W{1'b0}}, slot_index_i};
  assign widx     = sidx_ext[IDX_W-1:0];
  assign tk_ext   = {{TICKET_BITS{1'b0}}, tickets_in_i};

  // sweep engine and slot table
  logic [CNT_W-1:0] cnt_q;
  logic             pvld_q;
  logic [IDX_W-1:0] pidx_q;
  logic             sweeping, issue, sweep_done;
  logic [ORDER_W-1:0]     rd_order;
  logic [TICKET_BITS-1:0] rd_tickets;

  assign sweeping   = (state_q inside {ST_SUM, ST_SCAN, ST_FIFO});
  assign issue      = sweeping && (cnt_q != CNT_W'(SLOT_COUNT));
  assign sweep_done = sweeping && !issue && !pvld_q;

  lftp_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .TICKET_BITS(TICKET_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (accept && (req_type_i == REQ_LOAD) && idx_ok),
    .waddr_i   (widx),
    .worder_i  (order_in_i),
    .wtickets_i(tk_ext[TICKET_BITS-1:0]),
    .re_i      (issue),
    .raddr_i   (cnt_q[IDX_W-1:0]),
    .rorder_o  (rd_order),
    .rtickets_o(rd_tickets)
  );

  // lottery draw and remainder
  logic [DRAW_W-1:0] tick_q, prod_q, draw_q;
  logic [TOT_W-1:0]  acc_q, sum_w, rem;
  logic              mod_start, mod_done;

  lftp_mod_unit #(
    .DIV_W(TOT_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(draw_q),
    .divisor_i (acc_q),
    .done_o    (mod_done),
    .rem_o     (rem)
  );

  // shared accumulator: ticket total in the sum pass, running sum in the scan pass
  logic [SLOT_COUNT-1:0] runnable_q, has_run_q;
  logic                  cur_run;

  assign cur_run = pvld_q && runnable_q[pidx_q];
  assign sum_w   = acc_q + TOT_W'(rd_tickets);

  // sequencer
  logic fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mod_start = 1'b0;
    fin       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_PICK)) begin
          state_d = pick_mode_q ? ST_MUL : ST_FIFO;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_SUM;
      ST_SUM: begin
        if (sweep_done) begin
          if (acc_q == '0) begin
            state_d = ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (mod_done) state_d = ST_SCAN;
      end
      ST_SCAN, ST_FIFO: begin
        if (sweep_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control state
  logic             best_vld_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [ORDER_W-1:0] best_ord_q;
  logic             out_vld_q, out_grant_q, out_first_q;
  logic [SLOT_IDX_W-1:0] out_slot_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [IDX_W+SLOT_IDX_W-1:0] gs_ext;
  logic             fifo_take, scan_take;

  assign gs_ext    = {{SLOT_IDX_W{1'b0}}, best_idx_q};
  assign fifo_take = (state_q == ST_FIFO) && cur_run &&
                     (!best_vld_q || (rd_order < best_ord_q));
  assign scan_take = (state_q == ST_SCAN) && cur_run && !best_vld_q && (sum_w > rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pvld_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      runnable_q  <= '0;
      has_run_q   <= '0;
      out_vld_q   <= 1'b0;
      out_grant_q <= 1'b0;
      out_first_q <= 1'b0;
      out_slot_q  <= '0;
    end else begin
      if (sweeping) begin
        pvld_q <= issue;
        if (issue) cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        pvld_q <= 1'b0;
        cnt_q  <= '0;
      end

      if (accept) begin
        best_vld_q <= 1'b0;
      end else if (fifo_take || scan_take) begin
        best_vld_q <= 1'b1;
      end

      out_vld_q <= 1'b0;
      if (accept) begin
        case (req_type_i)
          REQ_LOAD: begin
            if (idx_ok) begin
              runnable_q[widx] <= runnable_in_i;
              has_run_q[widx]  <= 1'b0;
            end
          end
          REQ_SET_RUN: begin
            if (idx_ok) runnable_q[widx] <= runnable_in_i;
          end
          default: ;
        endcase
        if (req_type_i != REQ_PICK) begin
          out_vld_q   <= 1'b1;
          out_grant_q <= 1'b0;
          out_first_q <= 1'b0;
          out_slot_q  <= '0;
        end
      end else if (fin) begin
        out_vld_q   <= 1'b1;
        out_grant_q <= best_vld_q;
        out_first_q <= best_vld_q && !has_run_q[best_idx_q];
        out_slot_q  <= best_vld_q ? gs_ext[SLOT_IDX_W-1:0] : '0;
        if (best_vld_q) begin
          runnable_q[best_idx_q] <= 1'b0;
          has_run_q[best_idx_q]  <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) tick_q <= tick_now_i;
    if (state_q == ST_MUL) prod_q <= DRAW_W'(lcg_mul_q * tick_q);
    if (state_q == ST_ADD) draw_q <= prod_q + lcg_inc_q;
    if (issue) pidx_q <= cnt_q[IDX_W-1:0];
    if (!sweeping) begin
      acc_q <= '0;
    end else if (cur_run) begin
      acc_q <= sum_w;
    end
    if (fifo_take || scan_take) begin
      best_idx_q <= pidx_q;
      best_ord_q <= rd_order;
    end
    if (fin) out_idx_q <= best_idx_q;
  end

  assign done_o         = out_vld_q;
  assign granted_o      = out_grant_q;
  assign granted_slot_o = out_slot_q;
  assign first_run_o    = out_first_q;

  // a result is only shown once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && first_run_o) |-> granted_o)
    else $error("first-run flag without a grant");

  // granted slot must be retired in the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_grant_q) |-> (!runnable_q[out_idx_q] && has_run_q[out_idx_q]))
    else $error("granted slot still runnable or not marked as run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_DIV))
    else $error("remainder finished outside divide phase");

  // the remainder never starts on a zero ticket total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |-> (acc_q != '0))
    else $error("remainder started with zero divisor");

endmodule
